### rtl/asd_pkg.sv
package asd_pkg;

	// Q16 constants of the level calculation.
	localparam int unsigned FRAC_BITS = 16;
	localparam logic [17:0] TEN_LOG10_TWO_Q16 = 18'd197283;
	localparam logic [4:0] FULL_SCALE_EXP = 5'd27;
	localparam logic [6:0] LEVEL_OFFSET_DB = 7'd96;
	localparam int unsigned LEVEL_BITS = 15;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 15'h7FFF;
	localparam int unsigned LEVEL_SHIFT = 24;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accum;
		logic mul_load_nq;
		logic mul_load_s2;
		logic mul_step;
		logic norm_load_num;
		logic norm_load_n;
		logic norm_step;
		logic log_save_num;
		logic log_save_n;
		logic calc_prod;
		logic calc_level;
		logic zero_level;
		logic finish;
	} asd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mul_done;
		logic norm_done;
		logic trivial;
	} asd_status_t;

	// log2(1 + i/16) in Q16, for i from 0 to 16.
	function automatic logic [16:0] log_frac(input logic [4:0] idx);
		logic [16:0] v;
		begin
			case (idx)
				5'd0: v = 17'd0;
				5'd1: v = 17'd5732;
				5'd2: v = 17'd11136;
				5'd3: v = 17'd16248;
				5'd4: v = 17'd21098;
				5'd5: v = 17'd25711;
				5'd6: v = 17'd30109;
				5'd7: v = 17'd34312;
				5'd8: v = 17'd38336;
				5'd9: v = 17'd42196;
				5'd10: v = 17'd45903;
				5'd11: v = 17'd49472;
				5'd12: v = 17'd52910;
				5'd13: v = 17'd56229;
				5'd14: v = 17'd59434;
				5'd15: v = 17'd62535;
				default: v = 17'd65536;
			endcase
			return v;
		end
	endfunction

endpackage

### rtl/audio_silence_detector.sv
// One sample is accepted per cycle while a buffer accumulates; after a last sample
// the result is computed with the shift-add multiplier and the bit-serial
// leading-one search, both sized by CW (bits of the sample count, 13 by default).
// No sample is accepted during evaluation.
// Reset (arst_n low, asynchronous) clears the accumulators, the running average,
// the threshold register and the output valid flag.
module audio_silence_detector
	import asd_pkg::*;
#(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    sample,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  silent,
	output logic [LEVEL_BITS-1:0] buffer_level,
	output logic [LEVEL_BITS-1:0] average_level
);

	localparam logic REG_SILENCE_LEVEL = 1'b0;

	logic [6:0]  silence_level_q;
	asd_cmd_t    cmd;
	asd_status_t status;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SILENCE_LEVEL) ? {25'b0, silence_level_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_level_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_SILENCE_LEVEL)) begin
			silence_level_q <= pwdata[6:0];
		end
	end

	asd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	asd_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.sample        (sample),
		.silence_level (silence_level_q),
		.silent        (silent),
		.buffer_level  (buffer_level),
		.average_level (average_level)
	);

endmodule

### rtl/asd_dp.sv
module asd_dp
	import asd_pkg::*;
#(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  asd_cmd_t              cmd,
	output asd_status_t           status,
	input  logic signed [15:0]    sample,
	input  logic [6:0]            silence_level,
	output logic                  silent,
	output logic [LEVEL_BITS-1:0] buffer_level,
	output logic [LEVEL_BITS-1:0] average_level
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = CW + 16;
	localparam int QW = CW + 30;
	localparam int PW = 2 * SW;
	localparam int EW = $clog2(PW);
	localparam int LGW = EW + FRAC_BITS;
	localparam int LW = LGW + 3;
	localparam int PRW = LW + 19;
	localparam int AW = ((PRW > 40) ? PRW : 40) + 1;
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SAMPLES);

	logic [CW-1:0]        count_q;
	logic signed [SW-1:0] sum_q;
	logic [QW-1:0]        sq_q;
	logic [LEVEL_BITS-1:0] avg_q;
	logic [PW-1:0]        mcand_q;
	logic [SW-1:0]        mplr_q;
	logic [PW-1:0]        prod_q;
	logic [PW-1:0]        nq_q;
	logic [PW-1:0]        norm_q;
	logic [EW-1:0]        exp_q;
	logic [LGW-1:0]       lnum_q;
	logic [LGW-1:0]       ln_q;
	logic signed [PRW-1:0] acc_q;
	logic [LEVEL_BITS-1:0] level_q;

	logic signed [31:0]   sq_sample;
	logic [SW-1:0]        mag;
	logic [15:0]          mant;
	logic [16:0]          lo;
	logic [16:0]          hi;
	logic [12:0]          frac_step;
	logic [24:0]          interp;
	logic [LGW-1:0]       log_val;
	logic signed [LW-1:0] l2;
	logic signed [AW-1:0] sum_db;
	logic signed [AW-1:0] shifted;
	logic [LEVEL_BITS-1:0] level_next;
	logic [LEVEL_BITS:0]  avg_sum;
	logic [LEVEL_BITS-1:0] avg_next;

	assign sq_sample = sample * sample;
	assign mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

	// Status toward the controller.
	assign status.mul_done = (mplr_q == '0);
	assign status.norm_done = norm_q[PW-1];
	assign status.trivial = (count_q == '0) || (nq_q <= prod_q);

	// Log2 of the normalized word: exponent, table entry and interpolation.
	// Adjacent table entries differ by less than 2^13.
	assign mant = norm_q[PW-2 -: 16];
	assign lo = log_frac({1'b0, mant[15:12]});
	assign hi = log_frac({1'b0, mant[15:12]} + 5'd1);
	assign frac_step = 13'(hi - lo);
	assign interp = frac_step * mant[11:0];
	assign log_val = {exp_q, {FRAC_BITS{1'b0}}} + LGW'(lo) + LGW'(interp[24:12]);

	// Level in Q16 log2 units relative to full scale.
	assign l2 = $signed({3'b000, lnum_q}) - $signed({2'b00, ln_q, 1'b0})
		- $signed(LW'({FULL_SCALE_EXP, {FRAC_BITS{1'b0}}}));

	// Offset, scale to Q7.8 and clamp.
	assign sum_db = AW'(acc_q) + $signed(AW'({LEVEL_OFFSET_DB, 32'b0}));
	assign shifted = sum_db >>> LEVEL_SHIFT;
	always_comb begin
		if (sum_db <= 0) begin
			level_next = '0;
		end else if (shifted > $signed(AW'(LEVEL_MAX))) begin
			level_next = LEVEL_MAX;
		end else begin
			level_next = shifted[LEVEL_BITS-1:0];
		end
	end

	assign avg_sum = {1'b0, avg_q} + {1'b0, level_q};
	assign avg_next = avg_sum[LEVEL_BITS:1];

	// Accumulators and running average.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			avg_q <= '0;
		end else if (cmd.finish) begin
			count_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			avg_q <= avg_next;
		end else if (cmd.accum && (count_q < MAX_COUNT)) begin
			count_q <= count_q + 1'b1;
			sum_q <= sum_q + SW'(sample);
			sq_q <= sq_q + QW'(sq_sample[30:0]);
		end
	end

	// Shift-add multiplier shared by n*square_sum and sum^2.
	always_ff @(posedge clk) begin
		if (cmd.mul_load_nq) begin
			mcand_q <= PW'(sq_q);
			mplr_q <= SW'(count_q);
			prod_q <= '0;
		end else if (cmd.mul_load_s2) begin
			nq_q <= prod_q;
			mcand_q <= PW'(mag);
			mplr_q <= mag;
			prod_q <= '0;
		end else if (cmd.mul_step) begin
			if (mplr_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
			mplr_q <= mplr_q >> 1;
		end
	end

	// Leading-one search, one bit per cycle.
	always_ff @(posedge clk) begin
		if (cmd.norm_load_num) begin
			norm_q <= nq_q - prod_q;
			exp_q <= EW'(PW - 1);
		end else if (cmd.norm_load_n) begin
			norm_q <= PW'(count_q);
			exp_q <= EW'(PW - 1);
		end else if (cmd.norm_step && !norm_q[PW-1]) begin
			norm_q <= norm_q << 1;
			exp_q <= exp_q - 1'b1;
		end
	end

	// Log results, scaling product and level.
	always_ff @(posedge clk) begin
		if (cmd.log_save_num) begin
			lnum_q <= log_val;
		end
		if (cmd.log_save_n) begin
			ln_q <= log_val;
		end
		if (cmd.calc_prod) begin
			acc_q <= l2 * $signed({1'b0, TEN_LOG10_TWO_Q16});
		end
		if (cmd.zero_level) begin
			level_q <= '0;
		end else if (cmd.calc_level) begin
			level_q <= level_next;
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			silent <= (avg_next < {silence_level, 8'b0});
			buffer_level <= level_q;
			average_level <= avg_next;
		end
	end

endmodule

### rtl/asd_ctrl.sv
module asd_ctrl
	import asd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        last,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  asd_status_t status,
	output asd_cmd_t    cmd
);

	typedef enum logic [3:0] {
		IDLE,
		LOAD_NQ,
		MUL_NQ,
		MUL_S2,
		CHECK,
		NORM_NUM,
		NORM_N,
		LOG_N,
		PROD,
		LEVEL,
		DONE
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   accept;
	logic   out_free;

	assign in_ready = (state_q == IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// Command decode and next state.
	always_comb begin
		cmd = '0;
		state_next = state_q;
		unique case (state_q)
			IDLE: begin
				cmd.accum = accept;
				if (accept && last) begin
					state_next = LOAD_NQ;
				end
			end
			LOAD_NQ: begin
				cmd.mul_load_nq = 1'b1;
				state_next = MUL_NQ;
			end
			MUL_NQ: begin
				if (status.mul_done) begin
					cmd.mul_load_s2 = 1'b1;
					state_next = MUL_S2;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			MUL_S2: begin
				if (status.mul_done) begin
					state_next = CHECK;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			CHECK: begin
				if (status.trivial) begin
					cmd.zero_level = 1'b1;
					state_next = DONE;
				end else begin
					cmd.norm_load_num = 1'b1;
					state_next = NORM_NUM;
				end
			end
			NORM_NUM: begin
				if (status.norm_done) begin
					cmd.log_save_num = 1'b1;
					cmd.norm_load_n = 1'b1;
					state_next = NORM_N;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			NORM_N: begin
				if (status.norm_done) begin
					state_next = LOG_N;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			LOG_N: begin
				cmd.log_save_n = 1'b1;
				state_next = PROD;
			end
			PROD: begin
				cmd.calc_prod = 1'b1;
				state_next = LEVEL;
			end
			LEVEL: begin
				cmd.calc_level = 1'b1;
				state_next = DONE;
			end
			DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_next = IDLE;
				end
			end
			default: begin
				state_next = IDLE;
			end
		endcase
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.finish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// A new result never overwrites one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid || out_ready))
		else $error("result overwritten");

	// A last sample starts the evaluation sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (state_q == LOAD_NQ))
		else $error("evaluation not started");

	// The multiplier and normalizer loads and the finish command never collide.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul_load_nq, cmd.mul_load_s2, cmd.norm_load_num, cmd.norm_load_n,
			cmd.finish}))
		else $error("datapath load collision");

endmodule
